[rtl/isub_pkg.sv]
// Shared types and constants for the interval set subtractor.
package isub_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VALUE_W         = 32;
    localparam int TOTAL_W         = 33;
    localparam int ENTRY_W         = 2 * VALUE_W;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INVERTED = 2'd2;

    localparam logic [1:0] CFG_UNIV_LOW  = 2'd0;
    localparam logic [1:0] CFG_UNIV_HIGH = 2'd1;

    localparam logic OP_RESTART  = 1'b0;
    localparam logic OP_SUBTRACT = 1'b1;

    typedef enum logic [1:0] {
        K_RESTART,
        K_SUBTRACT,
        K_INVERTED
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  lo;
        logic [VALUE_W-1:0]  hi;
    } t_req;

endpackage

[rtl/isub_ram.sv]
// Generic single write port RAM with registered read.
module isub_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/isub_front.sv]
// Front end: accept requests, classify them and queue them for the back end.
module isub_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [isub_pkg::VALUE_W-1:0] i_block_low,
    input  logic [isub_pkg::VALUE_W-1:0] i_block_high,
    input  logic [isub_pkg::VALUE_W-1:0] i_univ_low,
    input  logic [isub_pkg::VALUE_W-1:0] i_univ_high,
    output logic                        o_req_valid,
    input  logic                        i_req_ready,
    output isub_pkg::t_req              o_req
);

    isub_pkg::t_req r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    isub_pkg::t_req n_req;
    logic           push;
    logic           pop;

    always_comb begin
        if (i_opcode == isub_pkg::OP_RESTART) begin
            n_req.kind = (i_univ_low > i_univ_high) ? isub_pkg::K_INVERTED
                                                     : isub_pkg::K_RESTART;
            n_req.lo   = i_univ_low;
            n_req.hi   = i_univ_high;
        end else begin
            n_req.kind = (i_block_low > i_block_high) ? isub_pkg::K_INVERTED
                                                       : isub_pkg::K_SUBTRACT;
            n_req.lo   = i_block_low;
            n_req.hi   = i_block_high;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/isub_back.sv]
// Back end: walk the interval table, rebuild it in the other bank, report results.
module isub_back #(
    parameter int TABLE_DEPTH = isub_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  isub_pkg::t_req                      i_req,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [isub_pkg::VALUE_W-1:0]        o_lowest_allowed,
    output logic                                o_none_allowed,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_entries_used,
    output logic [isub_pkg::TOTAL_W-1:0]        o_allowed_total,
    output logic [1:0]                          o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int VW = isub_pkg::VALUE_W;
    localparam int TW = isub_pkg::TOTAL_W;
    localparam int EW = isub_pkg::ENTRY_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_SPLIT,
        S_OUT
    } t_state;

    t_state          r_state;
    logic            r_bank;
    logic [CW-1:0]   r_count;
    logic [TW-1:0]   r_total;
    logic [VW-1:0]   r_low;
    logic [CW-1:0]   r_idx;
    logic            r_dv;
    logic [CW-1:0]   r_wr;
    logic [TW-1:0]   r_sum;
    logic [VW-1:0]   r_wlow;
    logic [VW-1:0]   r_bl;
    logic [VW-1:0]   r_bh;
    logic [VW-1:0]   r_pend_lo;
    logic [VW-1:0]   r_pend_hi;
    logic [1:0]      r_status;
    logic            r_ovalid;
    logic [VW-1:0]   r_o_low;
    logic            r_o_none;
    logic [CW-1:0]   r_o_cnt;
    logic [TW-1:0]   r_o_total;
    logic [1:0]      r_o_status;

    logic [EW-1:0]   rd0;
    logic [EW-1:0]   rd1;
    logic [EW-1:0]   ent;
    logic [VW-1:0]   e_lo;
    logic [VW-1:0]   e_hi;
    logic            miss;
    logic            keep_l;
    logic            keep_r;
    logic            split;
    logic            have;
    logic [VW-1:0]   p_lo;
    logic [VW-1:0]   p_hi;
    logic            we;
    logic            wbank;
    logic [AW-1:0]   waddr;
    logic [VW-1:0]   w_lo;
    logic [VW-1:0]   w_hi;
    logic [TW-1:0]   w_size;
    logic            walk_end;
    logic            take;
    logic            restart;

    assign ent    = r_bank ? rd1 : rd0;
    assign e_lo   = ent[VW-1:0];
    assign e_hi   = ent[EW-1:VW];
    assign miss   = (r_bh < e_lo) || (r_bl > e_hi);
    assign keep_l = r_bl > e_lo;
    assign keep_r = r_bh < e_hi;
    assign split  = keep_l && keep_r;
    assign have   = miss || keep_l || keep_r;

    always_comb begin
        if (miss) begin
            p_lo = e_lo;
            p_hi = e_hi;
        end else if (keep_l) begin
            p_lo = e_lo;
            p_hi = r_bl - 1'b1;
        end else begin
            p_lo = r_bh + 1'b1;
            p_hi = e_hi;
        end
    end

    assign walk_end = !r_dv && (r_idx == r_count);
    assign take     = (r_state == S_IDLE) && i_req_valid;
    assign restart  = take && (i_req.kind == isub_pkg::K_RESTART);

    always_comb begin
        we    = 1'b0;
        wbank = ~r_bank;
        waddr = r_wr[AW-1:0];
        w_lo  = p_lo;
        w_hi  = p_hi;
        unique case (r_state)
            S_INIT: begin
                we    = 1'b1;
                wbank = 1'b0;
                waddr = '0;
                w_lo  = '0;
                w_hi  = '1;
            end
            S_IDLE: begin
                we    = restart;
                wbank = r_bank;
                waddr = '0;
                w_lo  = i_req.lo;
                w_hi  = i_req.hi;
            end
            S_WALK: begin
                we = r_dv && have;
            end
            S_SPLIT: begin
                we   = 1'b1;
                w_lo = r_pend_lo;
                w_hi = r_pend_hi;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign w_size = {1'b0, w_hi} - {1'b0, w_lo} + TW'(1);

    isub_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we && !wbank),
        .i_waddr (waddr),
        .i_wdata ({w_hi, w_lo}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd0)
    );

    isub_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we && wbank),
        .i_waddr (waddr),
        .i_wdata ({w_hi, w_lo}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd1)
    );

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_lowest_allowed = r_o_low;
    assign o_none_allowed   = r_o_none;
    assign o_entries_used   = r_o_cnt;
    assign o_allowed_total  = r_o_total;
    assign o_status         = r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bank   <= 1'b0;
            r_count  <= CW'(1);
            r_total  <= TW'(1) << VW;
            r_low    <= '0;
            r_idx    <= '0;
            r_dv     <= 1'b0;
            r_wr     <= '0;
            r_sum    <= '0;
            r_status <= isub_pkg::ST_DONE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (take) begin
                        r_bl     <= i_req.lo;
                        r_bh     <= i_req.hi;
                        r_idx    <= '0;
                        r_dv     <= 1'b0;
                        r_wr     <= '0;
                        r_sum    <= '0;
                        case (i_req.kind)
                            isub_pkg::K_RESTART: begin
                                r_count  <= CW'(1);
                                r_total  <= w_size;
                                r_low    <= i_req.lo;
                                r_status <= isub_pkg::ST_DONE;
                                r_state  <= S_OUT;
                            end
                            isub_pkg::K_SUBTRACT: begin
                                r_status <= isub_pkg::ST_DONE;
                                if (r_count == CW'(TABLE_DEPTH)) begin
                                    r_state <= S_CHECK;
                                end else if (r_count != '0) begin
                                    r_state <= S_WALK;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_status <= isub_pkg::ST_INVERTED;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_dv && split) begin
                        r_status <= isub_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else if (walk_end) begin
                        r_idx   <= '0;
                        r_state <= S_WALK;
                    end else if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (walk_end) begin
                        r_bank  <= ~r_bank;
                        r_count <= r_wr;
                        r_total <= r_sum;
                        r_low   <= (r_wr == '0) ? '0 : r_wlow;
                        r_state <= S_OUT;
                    end else begin
                        if (we) begin
                            r_sum <= r_sum + w_size;
                            r_wr  <= r_wr + 1'b1;
                            if (r_wr == '0) begin
                                r_wlow <= w_lo;
                            end
                        end
                        if (r_dv && split) begin
                            r_pend_lo <= r_bh + 1'b1;
                            r_pend_hi <= e_hi;
                            r_dv      <= 1'b0;
                            r_state   <= S_SPLIT;
                        end else if (r_idx < r_count) begin
                            r_idx <= r_idx + 1'b1;
                            r_dv  <= 1'b1;
                        end else begin
                            r_dv <= 1'b0;
                        end
                    end
                end
                S_SPLIT: begin
                    r_sum <= r_sum + w_size;
                    r_wr  <= r_wr + 1'b1;
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    r_state <= S_WALK;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_low    <= r_low;
                        r_o_none   <= (r_count == '0);
                        r_o_cnt    <= r_count;
                        r_o_total  <= r_total;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/interval_set_subtractor_core.sv]
// Top level of the interval set subtractor: config registers, front end, back end.
//
//  channel   direction  handshake                  payload
//  request   in         i_valid / o_ready          i_opcode, i_block_low, i_block_high
//  result    out        o_valid / i_ready          lowest, none, entries, total, status
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Restart, ignored or empty-table request: the back end goes straight to output.
// Subtract: the back end walks the table through its single read port and writes the
// pieces it keeps, a state per split; a full table is first scanned for overflow.
// After reset the back end loads the full value range into the table.
// A two-entry queue lets requests wait while the back end or the result stalls.
module interval_set_subtractor_core #(
    parameter int TABLE_DEPTH = isub_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [isub_pkg::VALUE_W-1:0]        i_block_low,
    input  logic [isub_pkg::VALUE_W-1:0]        i_block_high,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [isub_pkg::VALUE_W-1:0]        o_lowest_allowed,
    output logic                                o_none_allowed,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_entries_used,
    output logic [isub_pkg::TOTAL_W-1:0]        o_allowed_total,
    output logic [1:0]                          o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [isub_pkg::VALUE_W-1:0]        i_cfg_data
);

    logic [isub_pkg::VALUE_W-1:0] r_univ_low;
    logic [isub_pkg::VALUE_W-1:0] r_univ_high;
    logic                         req_valid;
    logic                         req_ready;
    isub_pkg::t_req               req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_univ_low  <= '0;
            r_univ_high <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                isub_pkg::CFG_UNIV_LOW:  r_univ_low  <= i_cfg_data;
                isub_pkg::CFG_UNIV_HIGH: r_univ_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    isub_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_univ_low   (r_univ_low),
        .i_univ_high  (r_univ_high),
        .o_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .o_req        (req)
    );

    isub_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (req_valid),
        .o_req_ready      (req_ready),
        .i_req            (req),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_lowest_allowed (o_lowest_allowed),
        .o_none_allowed   (o_none_allowed),
        .o_entries_used   (o_entries_used),
        .o_allowed_total  (o_allowed_total),
        .o_status         (o_status)
    );

endmodule
